FILE: hw/rtl/sitda_pkg.sv
// ============================================================================
// sitda_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ============================================================================
package sitda_pkg;

    // Width of the incoming two's complement value
    localparam int VALUE_WIDTH = 32;

    // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int MAX_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

    // Character codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // Divide by ten through a reciprocal: q = (x * RECIP) >> (VALUE_WIDTH + 4),
    // exact for every VALUE_WIDTH-bit x since the rounding error stays below 16.
    localparam int RADIX       = 10;
    localparam int RECIP_SHIFT = VALUE_WIDTH + 4;
    localparam logic [RECIP_SHIFT:0] RECIP_POW = {1'b1, {RECIP_SHIFT{1'b0}}};
    localparam logic [RECIP_SHIFT:0] RECIP_FULL =
        (RECIP_POW + (RECIP_SHIFT + 1)'(RADIX - 1)) / (RECIP_SHIFT + 1)'(RADIX);
    localparam logic [VALUE_WIDTH:0] RECIP = RECIP_FULL[VALUE_WIDTH:0];
    localparam int MUL_W = 2 * VALUE_WIDTH + 1;

    // One classified conversion job
    typedef struct packed {
        logic                   negative;
        logic [VALUE_WIDTH-1:0] magnitude;
    } job_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

endpackage

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// ============================================================================
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output beat, most significant first, with a flag on the last one.
//
// Usage:
//   Input side is a queue: drive value and push; the beat is taken when full
//   is low. Output side is a queue: while empty is low, char_code/last_char
//   hold the oldest character; pop takes it. last_char marks the final
//   character of each number ('-' leads negative numbers).
//   An input stage registers sign and magnitude, a two-entry job queue feeds
//   the back end, which divides by ten at one digit per cycle (one reciprocal
//   multiplier) and then emits one character per cycle while pop keeps up.
//   The back end finishes one number, dividing and then emitting, before it
//   loads the next job from the queue.
//   While the receiver stalls, the back end holds its character and up to
//   three further numbers wait in the input stage and job queue, then full
//   rises. Reset empties every stage; no character is left pending.
// ============================================================================
module signed_int_to_decimal_ascii (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
    output logic                                     empty,
    input  logic                                     pop,
    output logic [7:0]                               char_code,
    output logic                                     last_char
);
    import sitda_pkg::*;

    logic job_push;
    logic job_full;
    job_t front_job;
    logic job_pop;
    logic job_empty;
    job_t queued_job;

    // Classify incoming values
    sitda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .value    (value),
        .job_push (job_push),
        .job_full (job_full),
        .job      (front_job)
    );

    // Decouple front and back
    sitda_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .full   (job_full),
        .wr_job (front_job),
        .pop    (job_pop),
        .empty  (job_empty),
        .rd_job (queued_job)
    );

    // Produce digits and emit text
    sitda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (queued_job),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last_char (last_char)
    );

endmodule

FILE: hw/rtl/sitda_front.sv
// ============================================================================
// sitda_front
// Input stage: takes one value per beat, splits it into sign and magnitude.
// ============================================================================
module sitda_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 job_push,
    input  logic                                 job_full,
    output sitda_pkg::job_t                      job
);
    import sitda_pkg::*;

    logic stage_valid_reg;
    logic stage_valid_next;
    job_t stage_job_reg;
    job_t classified;
    logic accept;

    // Classify: sign bit and unsigned magnitude (most negative maps to 2^(W-1))
    always_comb
    begin
        classified.negative  = value[VALUE_WIDTH-1];
        classified.magnitude = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1))
                                                     : value;
    end

    // Accept while the stage is empty or drains into the queue this cycle
    assign full   = stage_valid_reg && job_full;
    assign accept = push && !full;

    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (!job_full)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Hold the job until the queue takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_job_reg <= classified;
        end
    end

    assign job_push = stage_valid_reg;
    assign job      = stage_job_reg;

endmodule

FILE: hw/rtl/sitda_queue.sv
// ============================================================================
// sitda_queue
// Two-entry job queue between the input stage and the digit back end.
// ============================================================================
module sitda_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  sitda_pkg::job_t wr_job,
    input  logic            pop,
    output logic            empty,
    output sitda_pkg::job_t rd_job
);
    import sitda_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

FILE: hw/rtl/sitda_back.sv
// ============================================================================
// sitda_back
// Digit back end: divides by ten one digit per cycle, then emits the text
// most significant character first through an output register.
// ============================================================================
module sitda_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_empty,
    output logic            job_pop,
    input  sitda_pkg::job_t job,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      char_code,
    output logic            last_char
);
    import sitda_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [DIG_CNT_W-1:0]   ndig_reg;
    logic [DIG_IDX_W-1:0]   idx_reg;
    logic [3:0]             digit_reg [MAX_DIGITS];
    logic                   out_valid_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;

    logic [MUL_W-1:0]       product;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [3:0]             q_times_ten;
    logic [3:0]             remainder;
    logic                   out_ready;

    // Control decoded from state
    logic                   load_job;
    logic                   divide_step;
    logic                   emit_sign;
    logic                   emit_digit;

    // Divide by ten through the reciprocal; remainder needs only the low nibble
    assign product     = MUL_W'(mag_reg) * MUL_W'(RECIP);
    assign quotient    = VALUE_WIDTH'(product[MUL_W-1:RECIP_SHIFT]);
    assign q_times_ten = {quotient[0], 3'b000} + {quotient[2:0], 1'b0};
    assign remainder   = mag_reg[3:0] - q_times_ten;

    // Output register takes a beat when empty or drained this cycle
    assign out_ready = !out_valid_reg || pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (quotient == '0)
                begin
                    state_next = neg_reg ? BK_SIGN : BK_DIGIT;
                end
            end
            BK_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (out_ready && (idx_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        load_job    = 1'b0;
        divide_step = 1'b0;
        emit_sign   = 1'b0;
        emit_digit  = 1'b0;
        unique case (state_reg)
            BK_IDLE:   load_job    = !job_empty;
            BK_DIVIDE: divide_step = 1'b1;
            BK_SIGN:   emit_sign   = out_ready;
            BK_DIGIT:  emit_digit  = out_ready;
            default:   load_job    = 1'b0;
        endcase
    end

    assign job_pop = load_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_sign || emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: load job, peel digits, walk the digit buffer back down
    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            mag_reg  <= job.magnitude;
            neg_reg  <= job.negative;
            ndig_reg <= '0;
        end
        if (divide_step)
        begin
            digit_reg[ndig_reg[DIG_IDX_W-1:0]] <= remainder;
            mag_reg  <= quotient;
            ndig_reg <= ndig_reg + DIG_CNT_W'(1);
            idx_reg  <= ndig_reg[DIG_IDX_W-1:0];
        end
        if (emit_sign)
        begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end
        if (emit_digit)
        begin
            char_reg <= ASCII_ZERO + {4'b0000, digit_reg[idx_reg]};
            last_reg <= (idx_reg == '0);
            idx_reg  <= idx_reg - DIG_IDX_W'(1);
        end
    end

    assign empty     = !out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

FILE: tb/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// signed_int_to_decimal_ascii_tb
// Drives signed integers into the converter and checks every emitted
// character and last-character flag against a predicted decimal text.
// Directed extremes come first, then random values spread over all digit
// counts, with random idle bursts on both the push and the pop side.
// ============================================================================
module signed_int_to_decimal_ascii_tb;

    import sitda_pkg::*;

    localparam int RANDOM_ITEMS = 220;
    localparam int QUIET_TAIL   = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          push  = 1'b0;
    logic                          full;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          empty;
    logic                          pop   = 1'b0;
    logic [7:0]                    char_code;
    logic                          last_char;

    logic signed [VALUE_WIDTH-1:0] pending_values[$];
    char_beat_t                    expected_chars[$];
    int                            push_gap   = 0;
    int                            pop_gap    = 0;
    int                            mismatches = 0;
    int                            cycle_count = 0;

    signed_int_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code),
        .last_char (last_char)
    );

    // Clock and a single reset pulse
    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Append the decimal text of one value to the expected characters
    task automatic predict_decimal_text(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH:0] magnitude;
        logic [7:0]           digit_codes[$];
        logic                 negative;
        char_beat_t           beat;
        begin
            negative  = v[VALUE_WIDTH-1];
            // widen before negating so the most negative value stays exact
            magnitude = negative ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
            do
            begin
                digit_codes.push_front(ASCII_ZERO + 8'(magnitude % RADIX));
                magnitude = magnitude / RADIX;
            end
            while (magnitude != 0);
            if (negative)
            begin
                beat.code = ASCII_MINUS;
                beat.last = 1'b0;
                expected_chars.push_back(beat);
            end
            foreach (digit_codes[i])
            begin
                beat.code = digit_codes[i];
                beat.last = (i == digit_codes.size() - 1);
                expected_chars.push_back(beat);
            end
        end
    endtask

    // Random value of random bit length and sign, so every digit count shows up
    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] v;
        int                     bits;
        begin
            v = $urandom;
            case ($urandom_range(0, 3))
                0: ; // full-width random pattern
                1: v = $urandom_range(0, 99);
                default:
                begin
                    bits = $urandom_range(1, VALUE_WIDTH - 1);
                    v    = v & ((VALUE_WIDTH'(1) << bits) - 1'b1);
                    if ($urandom_range(0, 1))
                        v = -v;
                end
            endcase
            return v;
        end
    endfunction

    // Driver: present pending values, idle in short random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            value    <= '0;
            push_gap = 0;
        end
        else if (push && full)
        begin
            // hold the beat until it is taken
        end
        else
        begin
            if (push)
                predict_decimal_text(value);
            if (push_gap == 0 && pending_values.size() > QUIET_TAIL
                && $urandom_range(0, 3) == 0)
                push_gap = $urandom_range(1, 3);
            if (push_gap > 0)
            begin
                push_gap--;
                push <= 1'b0;
            end
            else if (pending_values.size() != 0)
            begin
                value <= pending_values.pop_front();
                push  <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // Monitor: check each taken character, stall pop in short random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop     <= 1'b0;
            pop_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected char beat, actual code %h last %b",
                             $time, char_code, last_char);
                    mismatches++;
                end
                else
                begin
                    if (char_code !== expected_chars[0].code)
                    begin
                        $display("%0t: char_code mismatch, expected %h actual %h",
                                 $time, expected_chars[0].code, char_code);
                        mismatches++;
                    end
                    if (last_char !== expected_chars[0].last)
                    begin
                        $display("%0t: last_char mismatch, expected %b actual %b",
                                 $time, expected_chars[0].last, last_char);
                        mismatches++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
            if (pop_gap == 0 && pending_values.size() > QUIET_TAIL
                && $urandom_range(0, 3) == 0)
                pop_gap = $urandom_range(1, 3);
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL signed_int_to_decimal_ascii");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        // zero, single digits, digit-count boundaries and both extremes
        pending_values.push_back(0);
        pending_values.push_back(1);
        pending_values.push_back(-1);
        pending_values.push_back(9);
        pending_values.push_back(10);
        pending_values.push_back(-9);
        pending_values.push_back(-10);
        pending_values.push_back(99);
        pending_values.push_back(100);
        pending_values.push_back(-100);
        pending_values.push_back(999999999);
        pending_values.push_back(1000000000);
        pending_values.push_back(-1000000000);
        pending_values.push_back(1234567890);
        pending_values.push_back(-123);
        pending_values.push_back(32'sh7FFFFFFF);
        pending_values.push_back(32'sh80000000);
        pending_values.push_back(32'sh80000001);
        pending_values.push_back(32'sh55555555);
        pending_values.push_back(32'shAAAAAAAA);
        pending_values.push_back(0);
        pending_values.push_back(32'shFFFFFFFE);

        repeat (RANDOM_ITEMS)
            pending_values.push_back(random_value());

        // drain: everything sent, everything received, then a quiet spell
        @(posedge clk);
        while (pending_values.size() != 0 || push || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS signed_int_to_decimal_ascii");
        else
            $display("FAIL signed_int_to_decimal_ascii");
        $finish;
    end

endmodule
